FILE: rtl/core/vacl_pkg.sv
`timescale 1ns / 1ps
// vacl_pkg: widths, beat types and pipeline stage types for the velocity limiter
// used by vacl_div_pipe and velocity_accel_limiter_unit; depends on nothing

package vacl_pkg;

  localparam int SPEED_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int CAP_BITS   = SPEED_BITS - 1;
  localparam int DT_BITS    = FRAC_BITS;
  localparam int PROD_BITS  = CAP_BITS + DT_BITS;
  localparam int BND_BITS   = SPEED_BITS + 1;
  localparam int SUM_BITS   = SPEED_BITS + 3;
  localparam int IDX_BITS   = 2;

  typedef enum logic [IDX_BITS-1:0] {
    REG_SPEED_CAP = 2'd0,
    REG_ACCEL_CAP = 2'd1,
    REG_DECEL_CAP = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [SPEED_BITS-1:0] present_speed;
    logic signed [SPEED_BITS-1:0] goal_speed;
    logic        [DT_BITS-1:0]    step_time;
  } vacl_in_t;

  typedef struct packed {
    logic signed [SPEED_BITS-1:0] next_speed;
    logic                         clipped;
  } vacl_out_t;

  typedef struct packed {
    logic                         vld;
    logic signed [SPEED_BITS-1:0] v;
    logic signed [SPEED_BITS-1:0] t;
    logic        [SPEED_BITS-1:0] av;
    logic                         rev;
    logic                         direct;
    logic                         limited;
    logic        [BND_BITS-1:0]   bound;
    logic        [PROD_BITS-1:0]  acc;
    logic        [PROD_BITS-1:0]  rem;
    logic        [FRAC_BITS-1:0]  quo;
  } vacl_pipe_t;

  typedef struct packed {
    logic                         vld;
    logic signed [SPEED_BITS-1:0] t;
    logic                         limited;
    logic signed [SUM_BITS-1:0]   delta;
    logic signed [SUM_BITS-1:0]   bound;
    logic signed [SUM_BITS-1:0]   vpb;
    logic signed [SUM_BITS-1:0]   vmb;
  } vacl_fin_t;

  function automatic logic signed [SPEED_BITS-1:0] sat_speed(
    input logic signed [SUM_BITS-1:0] x
  );
    logic signed [SUM_BITS-1:0] hi;
    logic signed [SUM_BITS-1:0] lo;
    hi = SUM_BITS'({1'b0, {(SPEED_BITS-1){1'b1}}});
    lo = -hi - SUM_BITS'(1);
    if (x > hi) begin
      sat_speed = hi[SPEED_BITS-1:0];
    end else if (x < lo) begin
      sat_speed = lo[SPEED_BITS-1:0];
    end else begin
      sat_speed = x[SPEED_BITS-1:0];
    end
  endfunction

endpackage

FILE: rtl/core/velocity_accel_limiter_unit.sv
`timescale 1ns / 1ps
// velocity_accel_limiter_unit: pipelined asymmetric slew-rate limiter on Q16.16 speeds
// depends on vacl_pkg and vacl_div_pipe
//
// usage:
//   a command beat (present speed, goal speed, timestep) is taken on in_data
//   at each clock edge where start is high and busy is low; busy stays low,
//   so a new command may enter every cycle
//   each command yields one result on out_data, shown for exactly one cycle
//   with out_strobe high, in command order
//   out_strobe rises once the command has passed the registered stages:
//   setup and multiply, bound check, 16 divider stages, blend multiply,
//   bound/sum stage, output register; throughput is one command per cycle
//   limits are written on the cfg channel (cfg_ready is always high) by index:
//   speed cap, accel cap, decel cap; write them only while no command is in
//   flight
//   reset clears the limits to zero (no limiting) and drops any command in
//   flight; the receiver cannot stall, results are never held back

module velocity_accel_limiter_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  vacl_pkg::vacl_in_t                 in_data,
  output logic                               out_strobe,
  output vacl_pkg::vacl_out_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vacl_pkg::IDX_BITS-1:0]      cfg_index,
  input  logic [vacl_pkg::CAP_BITS-1:0]      cfg_data
);

  localparam int S  = vacl_pkg::SPEED_BITS;
  localparam int F  = vacl_pkg::FRAC_BITS;
  localparam int C  = vacl_pkg::CAP_BITS;
  localparam int PW = vacl_pkg::PROD_BITS;
  localparam int BW = vacl_pkg::BND_BITS;
  localparam int SW = vacl_pkg::SUM_BITS;

  logic [C-1:0] speed_cap_r, accel_cap_r, decel_cap_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_cap_r <= '0;
      accel_cap_r <= '0;
      decel_cap_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (vacl_pkg::reg_idx_t'(cfg_index))
        vacl_pkg::REG_SPEED_CAP: speed_cap_r <= cfg_data;
        vacl_pkg::REG_ACCEL_CAP: accel_cap_r <= cfg_data;
        vacl_pkg::REG_DECEL_CAP: decel_cap_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: goal clamp, limit choice, limit * dt
  vacl_pkg::vacl_pipe_t s1_nxt, s1_r;
  logic signed [S:0]   tx, capx;
  logic signed [S-1:0] tc, veff;
  logic [S-1:0]        av, at;
  logic [C-1:0]        lim;
  logic                rev;

  always_comb begin
    tx   = {in_data.goal_speed[S-1], in_data.goal_speed};
    capx = {2'b00, speed_cap_r};
    tc   = in_data.goal_speed;
    if (speed_cap_r != '0) begin
      if (tx > capx) begin
        tc = capx[S-1:0];
      end else if (tx < -capx) begin
        tc = S'(-capx);
      end
    end
    veff = in_data.present_speed;
    av   = veff[S-1] ? S'(-veff) : S'(veff);
    at   = tc[S-1] ? S'(-tc) : S'(tc);
    rev  = 1'b0;
    lim  = decel_cap_r;
    if (tc == '0) begin
      lim = decel_cap_r;
    end else if (veff == '0) begin
      lim = accel_cap_r;
    end else if (veff[S-1] != tc[S-1]) begin
      if (decel_cap_r == '0) begin
        veff = '0;
        lim  = accel_cap_r;
      end else if (accel_cap_r == '0) begin
        lim = '0;
      end else begin
        lim = decel_cap_r;
        rev = 1'b1;
      end
    end else if (av < at) begin
      lim = accel_cap_r;
    end else begin
      lim = decel_cap_r;
    end
    s1_nxt         = '0;
    s1_nxt.vld     = start && !busy;
    s1_nxt.v       = veff;
    s1_nxt.t       = tc;
    s1_nxt.av      = av;
    s1_nxt.rev     = rev;
    s1_nxt.limited = (lim != '0);
    s1_nxt.acc     = PW'(lim) * PW'(in_data.step_time);
  end

  // stage 2: braking fits in the step or not, numerator for the blend
  vacl_pkg::vacl_pipe_t s2_nxt, s2_r;
  logic [C-1:0]  bq;
  logic [PW:0]   num;

  always_comb begin
    s2_nxt = s1_r;
    bq     = s1_r.acc[PW-1:F];
    num    = {1'b0, s1_r.acc} - ((PW+1)'(s1_r.av) << F);
    s2_nxt.bound  = BW'(bq);
    s2_nxt.direct = s1_r.rev && !(S'(bq) < s1_r.av);
    s2_nxt.rem    = num[PW-1:0];
    s2_nxt.quo    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      s2_r.vld <= 1'b0;
    end else begin
      s1_r.vld <= s1_nxt.vld;
      s2_r.vld <= s2_nxt.vld;
    end
    s1_r.v       <= s1_nxt.v;
    s1_r.t       <= s1_nxt.t;
    s1_r.av      <= s1_nxt.av;
    s1_r.rev     <= s1_nxt.rev;
    s1_r.direct  <= s1_nxt.direct;
    s1_r.limited <= s1_nxt.limited;
    s1_r.bound   <= s1_nxt.bound;
    s1_r.acc     <= s1_nxt.acc;
    s1_r.rem     <= s1_nxt.rem;
    s1_r.quo     <= s1_nxt.quo;
    s2_r.v       <= s2_nxt.v;
    s2_r.t       <= s2_nxt.t;
    s2_r.av      <= s2_nxt.av;
    s2_r.rev     <= s2_nxt.rev;
    s2_r.direct  <= s2_nxt.direct;
    s2_r.limited <= s2_nxt.limited;
    s2_r.bound   <= s2_nxt.bound;
    s2_r.acc     <= s2_nxt.acc;
    s2_r.rem     <= s2_nxt.rem;
    s2_r.quo     <= s2_nxt.quo;
  end

  // remaining time after braking to zero
  vacl_pkg::vacl_pipe_t dv;

  vacl_div_pipe u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .divisor (decel_cap_r),
    .din     (s2_r),
    .dout    (dv)
  );

  // stage m: accel * remaining time
  vacl_pkg::vacl_pipe_t m_nxt, m_r;

  always_comb begin
    m_nxt     = dv;
    m_nxt.acc = PW'(accel_cap_r) * PW'(dv.quo);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r.vld <= 1'b0;
    end else begin
      m_r.vld <= m_nxt.vld;
    end
    m_r.v       <= m_nxt.v;
    m_r.t       <= m_nxt.t;
    m_r.av      <= m_nxt.av;
    m_r.rev     <= m_nxt.rev;
    m_r.direct  <= m_nxt.direct;
    m_r.limited <= m_nxt.limited;
    m_r.bound   <= m_nxt.bound;
    m_r.acc     <= m_nxt.acc;
    m_r.rem     <= m_nxt.rem;
    m_r.quo     <= m_nxt.quo;
  end

  // stage a: final bound, change and the sums v + bound and v - bound
  vacl_pkg::vacl_fin_t a_nxt, a_r;
  logic [BW-1:0] bnd;

  always_comb begin
    bnd = m_r.direct ? (BW'(m_r.av) + BW'(m_r.acc[PW-1:F])) : m_r.bound;
    a_nxt.vld     = m_r.vld;
    a_nxt.t       = m_r.t;
    a_nxt.limited = m_r.limited || m_r.direct;
    a_nxt.bound   = SW'(bnd);
    a_nxt.delta   = SW'(m_r.t) - SW'(m_r.v);
    a_nxt.vpb     = SW'(m_r.v) + SW'(bnd);
    a_nxt.vmb     = SW'(m_r.v) - SW'(bnd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.vld <= 1'b0;
    end else begin
      a_r.vld <= a_nxt.vld;
    end
    a_r.t       <= a_nxt.t;
    a_r.limited <= a_nxt.limited;
    a_r.bound   <= a_nxt.bound;
    a_r.delta   <= a_nxt.delta;
    a_r.vpb     <= a_nxt.vpb;
    a_r.vmb     <= a_nxt.vmb;
  end

  // output stage: clamp the change, saturate
  vacl_pkg::vacl_out_t out_nxt, out_r;
  logic                out_vld_r;

  always_comb begin
    out_nxt.next_speed = a_r.t;
    out_nxt.clipped    = 1'b0;
    if (a_r.limited && (a_r.delta > a_r.bound)) begin
      out_nxt.next_speed = vacl_pkg::sat_speed(a_r.vpb);
      out_nxt.clipped    = 1'b1;
    end else if (a_r.limited && (a_r.delta < -a_r.bound)) begin
      out_nxt.next_speed = vacl_pkg::sat_speed(a_r.vmb);
      out_nxt.clipped    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= a_r.vld;
    end
    out_r <= out_nxt;
  end

  assign out_strobe = out_vld_r;
  assign out_data   = out_r;

  // checks
  a_direct_limited: assert property (@(posedge clk) disable iff (!rst_n)
    s2_r.vld && s2_r.direct |-> s2_r.rev && s2_r.limited)
    else $error("blend path without reversal");

  a_direct_moving: assert property (@(posedge clk) disable iff (!rst_n)
    m_r.vld && m_r.direct |-> m_r.av != '0)
    else $error("blend path with zero present speed");

  a_unclipped_goal: assert property (@(posedge clk) disable iff (!rst_n)
    a_r.vld && !out_nxt.clipped |=> out_strobe && out_data.next_speed == $past(a_r.t))
    else $error("unclipped result differs from goal");

endmodule

FILE: rtl/core/vacl_div_pipe.sv
`timescale 1ns / 1ps
// vacl_div_pipe: restoring divider, one quotient bit per register stage
// uses vacl_pkg for the stage type; side data rides along with each beat

module vacl_div_pipe (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [vacl_pkg::CAP_BITS-1:0]    divisor,
  input  vacl_pkg::vacl_pipe_t             din,
  output vacl_pkg::vacl_pipe_t             dout
);

  localparam int N = vacl_pkg::FRAC_BITS;

  vacl_pkg::vacl_pipe_t st_r [N+1];

  assign st_r[0] = din;

  for (genvar k = 0; k < N; k++) begin : g_stage
    vacl_pkg::vacl_pipe_t st_nxt;
    logic [vacl_pkg::PROD_BITS-1:0] dsh;

    always_comb begin
      dsh = vacl_pkg::PROD_BITS'(divisor) << (N - 1 - k);
      st_nxt = st_r[k];
      if (st_r[k].rem >= dsh) begin
        st_nxt.rem = st_r[k].rem - dsh;
        st_nxt.quo[N-1-k] = 1'b1;
      end else begin
        st_nxt.quo[N-1-k] = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k+1].vld <= 1'b0;
      end else begin
        st_r[k+1].vld <= st_nxt.vld;
      end
      st_r[k+1].v       <= st_nxt.v;
      st_r[k+1].t       <= st_nxt.t;
      st_r[k+1].av      <= st_nxt.av;
      st_r[k+1].rev     <= st_nxt.rev;
      st_r[k+1].direct  <= st_nxt.direct;
      st_r[k+1].limited <= st_nxt.limited;
      st_r[k+1].bound   <= st_nxt.bound;
      st_r[k+1].acc     <= st_nxt.acc;
      st_r[k+1].rem     <= st_nxt.rem;
      st_r[k+1].quo     <= st_nxt.quo;
    end
  end

  assign dout = st_r[N];

endmodule
